### src/mfp_pkg.sv
// Shared types, register indexes and constant tables of the multi-function peripheral.
package mfp_pkg;

	// Command codes
	typedef enum logic [2:0] {
		CMD_READ    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_ADVANCE = 3'd2,
		CMD_GP_SET  = 3'd3,
		CMD_GP_CLR  = 3'd4,
		CMD_TB_EVT  = 3'd5,
		CMD_SET_PND = 3'd6,
		CMD_NOP     = 3'd7
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TMR,
		ST_SCAN,
		ST_FIN
	} state_t;

	localparam int REG_COUNT = 24;
	localparam int PRE_W     = 40;
	localparam int MC_W      = 42;

	// Register indexes
	localparam logic [4:0] R_GPIP  = 5'd0;
	localparam logic [4:0] R_AER   = 5'd1;
	localparam logic [4:0] R_IERA  = 5'd3;
	localparam logic [4:0] R_IERB  = 5'd4;
	localparam logic [4:0] R_IPRA  = 5'd5;
	localparam logic [4:0] R_IPRB  = 5'd6;
	localparam logic [4:0] R_ISRA  = 5'd7;
	localparam logic [4:0] R_ISRB  = 5'd8;
	localparam logic [4:0] R_IMRA  = 5'd9;
	localparam logic [4:0] R_IMRB  = 5'd10;
	localparam logic [4:0] R_VR    = 5'd11;
	localparam logic [4:0] R_TACR  = 5'd12;
	localparam logic [4:0] R_TBCR  = 5'd13;
	localparam logic [4:0] R_TCDCR = 5'd14;
	localparam logic [4:0] R_TADR  = 5'd15;
	localparam logic [4:0] R_TBDR  = 5'd16;
	localparam logic [4:0] R_TCDR  = 5'd17;
	localparam logic [4:0] R_TDDR  = 5'd18;

	// Prescaler reload: 313 times the divider
	localparam logic [15:0] PRE_LOAD [8] = '{16'd0, 16'd1252, 16'd3130, 16'd5008,
		16'd15650, 16'd20032, 16'd31300, 16'd62600};

	// Interrupt channel of each timer
	localparam logic [3:0] TMR_CHAN [4] = '{4'd13, 4'd8, 4'd5, 4'd4};

	localparam logic [7:0] GPIP_B7  = 8'h80;
	localparam logic [7:0] VR_BASE  = 8'hf0;

	// Result of one timer step
	typedef struct packed {
		logic                    run;
		logic                    fire;
		logic signed [PRE_W-1:0] pre;
		logic [7:0]              cnt;
	} tmr_res_t;

	// Register index from a byte offset, wrapped modulo 24
	function automatic logic [4:0] reg_index(input logic [5:0] off);
		logic [4:0] r;
		r = off[5:1];
		if (r >= 5'(REG_COUNT))
			r = r - 5'(REG_COUNT);
		return r;
	endfunction

	// Pending mask with one channel added if enabled
	function automatic logic [15:0] mark(input logic [15:0] ipr, input logic [15:0] ier,
		input logic [3:0] ch);
		return ipr | (ier & (16'd1 << ch));
	endfunction

endpackage

### src/mfp_tmr_unit.sv
// Shared timer step: prescaler subtract with saturation, underflow tick and reload.
module mfp_tmr_unit (
	input  logic [2:0]                       code,
	input  logic signed [mfp_pkg::PRE_W-1:0] pre,
	input  logic [7:0]                       cnt,
	input  logic [7:0]                       reload,
	input  logic signed [mfp_pkg::MC_W-1:0]  mc,
	output mfp_pkg::tmr_res_t                res
);
	localparam logic signed [42:0] MAXV = 43'sd549755813887;
	localparam logic signed [42:0] MINV = -43'sd549755813888;

	logic signed [42:0] diff;
	logic signed [39:0] p1;
	logic [7:0]         dec;

	// Subtract elapsed ticks, clamp to 40 bits
	always_comb begin
		diff = $signed({{3{pre[39]}}, pre}) - $signed({mc[41], mc});
		if (diff > MAXV)
			p1 = MAXV[39:0];
		else if (diff < MINV)
			p1 = MINV[39:0];
		else
			p1 = diff[39:0];
		dec = cnt - 8'd1;
	end

	// Underflow reloads the prescaler and ticks the counter
	always_comb begin
		res.run  = (code != 3'd0);
		res.fire = 1'b0;
		res.pre  = p1;
		res.cnt  = cnt;
		if (p1 < 0) begin
			res.pre = p1 + $signed({24'd0, mfp_pkg::PRE_LOAD[code]});
			res.fire = (dec == 8'd0);
			res.cnt = res.fire ? reload : dec;
		end
	end
endmodule

### src/multifunction_timer_interrupt_controller_core.sv
// Top level: register file, sequencer, shared timer unit and priority scan.
//
// channel | handshake             | payload
// in      | in_valid / in_ready   | command byte_offset write_data cpu_cycle cpu_ipl gpip_bit channel
// out     | out_valid / out_ready | read_data irq_valid irq_vector last
// cfg     | cfg_we                | cfg_wdata (mono_monitor)
//
// Bus, GPIP, event and pending commands: idle, then exec, which waits for a free output.
// Advance: exec, then 4 timer steps (one per cycle on the shared timer unit),
// then 16 channel scan steps (one channel test per cycle while the output
// is free) and a finish step.
// Reset clears the register file, counters, prescalers and the cycle mark.
// A stalled output holds the exec, scan and finish states; input is taken only when idle.
module multifunction_timer_interrupt_controller_core #(
	parameter longint unsigned CYCLE_WRAP = 64'd16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [5:0]  byte_offset,
	input  logic [7:0]  write_data,
	input  logic [23:0] cpu_cycle,
	input  logic [2:0]  cpu_ipl,
	input  logic [2:0]  gpip_bit,
	input  logic [3:0]  channel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        irq_valid,
	output logic [7:0]  irq_vector,
	output logic        last
);
	mfp_pkg::state_t state_q, state_d;

	logic [7:0]  rf_q [mfp_pkg::REG_COUNT];
	logic [7:0]  rf_d [mfp_pkg::REG_COUNT];
	logic [7:0]  tc_q [4];
	logic [7:0]  tc_d [4];
	logic signed [39:0] pre_q [4];
	logic signed [39:0] pre_d [4];
	logic [23:0] lastc_q;
	logic        mono_q;

	mfp_pkg::cmd_t cmd_q;
	logic [5:0]  off_q;
	logic [7:0]  wd_q;
	logic [23:0] cyc_q;
	logic [2:0]  ipl_q;
	logic [2:0]  gb_q;
	logic [3:0]  ch_in_q;

	logic [1:0]  t_q;
	logic [3:0]  ch_q;
	logic signed [41:0] mc_q;
	logic        hold_v_q;
	logic [7:0]  hold_vec_q;

	logic        o_valid_q, o_irq_q, o_last_q;
	logic [7:0]  o_rd_q, o_vec_q;

	logic        out_free, push, p_irq, p_last;
	logic [7:0]  p_rd, p_vec;
	logic        hold_v_d, mc_ld, lastc_ld;
	logic [7:0]  hold_vec_d;

	// Cycle distance times 96
	logic signed [34:0] el_raw, el;
	logic signed [41:0] el_x, mc_d;
	always_comb begin
		el_raw = $signed({11'd0, cyc_q}) - $signed({11'd0, lastc_q});
		el = (el_raw < 0) ? el_raw + $signed(35'(CYCLE_WRAP)) : el_raw;
		el_x = {{7{el[34]}}, el};
		mc_d = (el_x <<< 6) + (el_x <<< 5);
	end

	// Shared timer unit
	logic [2:0] t_code;
	mfp_pkg::tmr_res_t tres;
	always_comb begin
		case (t_q)
			2'd0:    t_code = rf_q[mfp_pkg::R_TACR][2:0];
			2'd1:    t_code = rf_q[mfp_pkg::R_TBCR][2:0];
			2'd2:    t_code = rf_q[mfp_pkg::R_TCDCR][6:4];
			default: t_code = rf_q[mfp_pkg::R_TCDCR][2:0];
		endcase
	end

	mfp_tmr_unit u_tmr (
		.code   (t_code),
		.pre    (pre_q[t_q]),
		.cnt    (tc_q[t_q]),
		.reload (rf_q[5'(mfp_pkg::R_TADR + 5'(t_q))]),
		.mc     (mc_q),
		.res    (tres)
	);

	// Interrupt registers as 16-bit pairs
	logic [15:0] ier16, ipr16, isr16, imr16, bitm, himask;
	logic pend_b, en_b, blocked, disp;
	always_comb begin
		ier16 = {rf_q[mfp_pkg::R_IERA], rf_q[mfp_pkg::R_IERB]};
		ipr16 = {rf_q[mfp_pkg::R_IPRA], rf_q[mfp_pkg::R_IPRB]};
		isr16 = {rf_q[mfp_pkg::R_ISRA], rf_q[mfp_pkg::R_ISRB]};
		imr16 = {rf_q[mfp_pkg::R_IMRA], rf_q[mfp_pkg::R_IMRB]};
		bitm = 16'd1 << ch_q;
		himask = 16'hfffe << ch_q;
		pend_b = ipr16[ch_q];
		en_b = ier16[ch_q];
		blocked = (|(isr16 & himask)) || !imr16[ch_q] || (ipl_q >= 3'd6);
		disp = pend_b && en_b && !blocked;
	end

	// Bus read value
	logic [4:0] ridx;
	logic [7:0] rval;
	always_comb begin
		ridx = mfp_pkg::reg_index(off_q);
		case (ridx)
			mfp_pkg::R_GPIP: rval = rf_q[mfp_pkg::R_GPIP] | (mono_q ? 8'd0 : mfp_pkg::GPIP_B7);
			mfp_pkg::R_TADR: rval = tc_q[0];
			mfp_pkg::R_TBDR: rval = tc_q[1];
			mfp_pkg::R_TCDR: rval = tc_q[2];
			mfp_pkg::R_TDDR: rval = tc_q[3];
			default:         rval = rf_q[ridx];
		endcase
		if (!off_q[0])
			rval = 8'd0;
	end

	assign out_free = !o_valid_q || out_ready;

	// Next state, state updates and result words
	logic [15:0] ipr_n, isr_n;
	logic [7:0]  gm, dec1;
	logic        cur, aer, edg;
	always_comb begin
		state_d = state_q;
		for (int i = 0; i < mfp_pkg::REG_COUNT; i++)
			rf_d[i] = rf_q[i];
		for (int i = 0; i < 4; i++) begin
			tc_d[i] = tc_q[i];
			pre_d[i] = pre_q[i];
		end
		push = 1'b0;
		p_rd = 8'd0;
		p_irq = 1'b0;
		p_vec = 8'd0;
		p_last = 1'b0;
		hold_v_d = hold_v_q;
		hold_vec_d = hold_vec_q;
		mc_ld = 1'b0;
		lastc_ld = 1'b0;
		ipr_n = ipr16;
		isr_n = isr16;
		gm = 8'd1 << gb_q;
		cur = |(rf_q[mfp_pkg::R_GPIP] & gm);
		aer = |(rf_q[mfp_pkg::R_AER] & gm);
		edg = 1'b0;
		dec1 = tc_q[1] - 8'd1;
		case (state_q)
			mfp_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = mfp_pkg::ST_EXEC;
			end
			mfp_pkg::ST_EXEC: begin
				if (cmd_q == mfp_pkg::CMD_ADVANCE) begin
					mc_ld = 1'b1;
					state_d = mfp_pkg::ST_TMR;
				end else if (out_free) begin
					push = 1'b1;
					p_last = 1'b1;
					state_d = mfp_pkg::ST_IDLE;
					case (cmd_q)
						mfp_pkg::CMD_READ: p_rd = rval;
						mfp_pkg::CMD_WRITE: begin
							if (off_q[0]) begin
								case (ridx)
									mfp_pkg::R_TACR: begin
										if (rf_q[ridx][3:0] == 4'd0 && wd_q[2:0] != 3'd0)
											pre_d[0] = $signed({24'd0,
												mfp_pkg::PRE_LOAD[wd_q[2:0]]});
									end
									mfp_pkg::R_TBCR: begin
										if (rf_q[ridx][3:0] == 4'd0 && wd_q[2:0] != 3'd0)
											pre_d[1] = $signed({24'd0,
												mfp_pkg::PRE_LOAD[wd_q[2:0]]});
									end
									mfp_pkg::R_TCDCR: begin
										if (rf_q[ridx][6:4] == 3'd0 && wd_q[6:4] != 3'd0)
											pre_d[2] = $signed({24'd0,
												mfp_pkg::PRE_LOAD[wd_q[6:4]]});
										if (rf_q[ridx][2:0] == 3'd0 && wd_q[2:0] != 3'd0)
											pre_d[3] = $signed({24'd0,
												mfp_pkg::PRE_LOAD[wd_q[2:0]]});
									end
									mfp_pkg::R_TADR: begin
										if (rf_q[mfp_pkg::R_TACR][3:0] == 4'd0)
											tc_d[0] = wd_q;
									end
									mfp_pkg::R_TBDR: begin
										if (rf_q[mfp_pkg::R_TBCR][3:0] == 4'd0)
											tc_d[1] = wd_q;
									end
									mfp_pkg::R_TCDR: begin
										if (rf_q[mfp_pkg::R_TCDCR][6:4] == 3'd0)
											tc_d[2] = wd_q;
									end
									mfp_pkg::R_TDDR: begin
										if (rf_q[mfp_pkg::R_TCDCR][2:0] == 3'd0)
											tc_d[3] = wd_q;
									end
									default: ;
								endcase
								if (ridx == mfp_pkg::R_ISRA || ridx == mfp_pkg::R_ISRB)
									rf_d[ridx] = rf_q[ridx] & wd_q;
								else
									rf_d[ridx] = wd_q;
							end
						end
						mfp_pkg::CMD_GP_SET, mfp_pkg::CMD_GP_CLR: begin
							if (cmd_q == mfp_pkg::CMD_GP_SET) begin
								edg = !cur && aer;
								rf_d[mfp_pkg::R_GPIP] = rf_q[mfp_pkg::R_GPIP] | gm;
							end else begin
								edg = cur && !aer;
								rf_d[mfp_pkg::R_GPIP] = rf_q[mfp_pkg::R_GPIP] & ~gm;
							end
							if (edg && gb_q == 3'd4)
								ipr_n = mfp_pkg::mark(ipr16, ier16, 4'd6);
							else if (edg && gb_q == 3'd5)
								ipr_n = mfp_pkg::mark(ipr16, ier16, 4'd7);
						end
						mfp_pkg::CMD_TB_EVT: begin
							if (rf_q[mfp_pkg::R_TBCR][3:0] == 4'd8) begin
								tc_d[1] = dec1;
								if (dec1 == 8'd0) begin
									tc_d[1] = rf_q[mfp_pkg::R_TBDR];
									ipr_n = mfp_pkg::mark(ipr16, ier16, 4'd8);
								end
							end
						end
						mfp_pkg::CMD_SET_PND: ipr_n = mfp_pkg::mark(ipr16, ier16, ch_in_q);
						default: ;
					endcase
					if (cmd_q != mfp_pkg::CMD_WRITE) begin
						rf_d[mfp_pkg::R_IPRA] = ipr_n[15:8];
						rf_d[mfp_pkg::R_IPRB] = ipr_n[7:0];
					end
				end
			end
			mfp_pkg::ST_TMR: begin
				if (tres.run) begin
					pre_d[t_q] = tres.pre;
					tc_d[t_q] = tres.cnt;
					if (tres.fire) begin
						ipr_n = mfp_pkg::mark(ipr16, ier16, mfp_pkg::TMR_CHAN[t_q]);
						rf_d[mfp_pkg::R_IPRA] = ipr_n[15:8];
						rf_d[mfp_pkg::R_IPRB] = ipr_n[7:0];
					end
				end
				if (t_q == 2'd3)
					state_d = mfp_pkg::ST_SCAN;
			end
			mfp_pkg::ST_SCAN: begin
				if (out_free) begin
					if (pend_b && (!en_b || disp))
						ipr_n = ipr16 & ~bitm;
					if (disp) begin
						isr_n = rf_q[mfp_pkg::R_VR][3] ? (isr16 | bitm) : (isr16 & ~bitm);
						if (hold_v_q) begin
							push = 1'b1;
							p_irq = 1'b1;
							p_vec = hold_vec_q;
						end
						hold_v_d = 1'b1;
						hold_vec_d = (rf_q[mfp_pkg::R_VR] & mfp_pkg::VR_BASE) + {4'd0, ch_q};
					end
					rf_d[mfp_pkg::R_IPRA] = ipr_n[15:8];
					rf_d[mfp_pkg::R_IPRB] = ipr_n[7:0];
					rf_d[mfp_pkg::R_ISRA] = isr_n[15:8];
					rf_d[mfp_pkg::R_ISRB] = isr_n[7:0];
					if (ch_q == 4'd0)
						state_d = mfp_pkg::ST_FIN;
				end
			end
			mfp_pkg::ST_FIN: begin
				if (out_free) begin
					push = 1'b1;
					p_last = 1'b1;
					p_irq = hold_v_q;
					p_vec = hold_v_q ? hold_vec_q : 8'd0;
					hold_v_d = 1'b0;
					lastc_ld = 1'b1;
					state_d = mfp_pkg::ST_IDLE;
				end
			end
			default: state_d = mfp_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == mfp_pkg::ST_IDLE);

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfp_pkg::ST_IDLE;
			for (int i = 0; i < mfp_pkg::REG_COUNT; i++)
				rf_q[i] <= 8'd0;
			for (int i = 0; i < 4; i++) begin
				tc_q[i] <= 8'd0;
				pre_q[i] <= '0;
			end
			lastc_q <= 24'd0;
			mono_q <= 1'b0;
			t_q <= 2'd0;
			ch_q <= 4'd15;
			hold_v_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			for (int i = 0; i < mfp_pkg::REG_COUNT; i++)
				rf_q[i] <= rf_d[i];
			for (int i = 0; i < 4; i++) begin
				tc_q[i] <= tc_d[i];
				pre_q[i] <= pre_d[i];
			end
			if (lastc_ld)
				lastc_q <= cyc_q;
			if (cfg_we)
				mono_q <= cfg_wdata;
			hold_v_q <= hold_v_d;
			if (state_q == mfp_pkg::ST_TMR)
				t_q <= t_q + 2'd1;
			else
				t_q <= 2'd0;
			if (state_q == mfp_pkg::ST_SCAN && out_free)
				ch_q <= ch_q - 4'd1;
			else if (state_q != mfp_pkg::ST_SCAN)
				ch_q <= 4'd15;
			if (push)
				o_valid_q <= 1'b1;
			else if (out_ready)
				o_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= mfp_pkg::cmd_t'(command);
			off_q <= byte_offset;
			wd_q <= write_data;
			cyc_q <= cpu_cycle;
			ipl_q <= cpu_ipl;
			gb_q <= gpip_bit;
			ch_in_q <= channel;
		end
		if (mc_ld)
			mc_q <= mc_d;
		hold_vec_q <= hold_vec_d;
		if (push) begin
			o_rd_q <= p_rd;
			o_irq_q <= p_irq;
			o_vec_q <= p_vec;
			o_last_q <= p_last;
		end
	end

	assign out_valid  = o_valid_q;
	assign read_data  = o_rd_q;
	assign irq_valid  = o_irq_q;
	assign irq_vector = o_vec_q;
	assign last       = o_last_q;

	// Checks
	a_irq_no_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_valid |-> read_data == 8'd0)
		else $error("read data on a vector word");
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !irq_valid |-> last && irq_vector == 8'd0)
		else $error("plain word not final");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mfp_pkg::ST_IDLE |-> !hold_v_q)
		else $error("held vector left behind");
endmodule
